// File: design/bfq_pkg.sv
// Package for the batched FIFO queue: sizes, opcodes, status codes and the
// item, result and control structs shared by every design file but bfq_ram.
// Depends on nothing.
`default_nettype none
package bfq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int LOG_DEPTH   = 16;
  localparam int ITEM_WIDTH  = 32;

  localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LCNT_W  = $clog2(LOG_DEPTH + 1);

  // Opcodes; codes five to seven are ignored.
  localparam logic [2:0] OP_ENQ  = 3'd0;
  localparam logic [2:0] OP_DEQ  = 3'd1;
  localparam logic [2:0] OP_DENQ = 3'd2;
  localparam logic [2:0] OP_DDEQ = 3'd3;
  localparam logic [2:0] OP_EXEC = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_RESULT = 2'd0;
  localparam logic [1:0] STAT_QFULL  = 2'd1;
  localparam logic [1:0] STAT_LFULL  = 2'd2;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [ITEM_WIDTH-1:0] item;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ITEM_WIDTH-1:0] item_out;
    logic                  found;
    logic                  last;
  } out_t;

  // One logged operation: kind is 1 for a dequeue, 0 for an enqueue.
  typedef struct packed {
    logic                  kind;
    logic [ITEM_WIDTH-1:0] item;
  } log_entry_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       found;
  } res_push_t;

  typedef struct packed {
    res_push_t push;
    logic      direct_lfull;
    logic      flush;
  } res_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINAL,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: design/bfq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module bfq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/bfq_ctrl.sv
// Sequencer of the batched FIFO queue: command FSM, log walk, queue head and
// count, log count, and the address and write controls of both memories.
// Depends on bfq_pkg.
`default_nettype none
module bfq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  bfq_pkg::in_t            op,
  output logic                    busy,
  output logic                    log_we,
  output logic [bfq_pkg::LADDR_W-1:0] log_waddr,
  output bfq_pkg::log_entry_t     log_wdata,
  output logic [bfq_pkg::LADDR_W-1:0] log_raddr,
  input  bfq_pkg::log_entry_t     log_rdata,
  output logic                    q_we,
  output logic [bfq_pkg::QADDR_W-1:0] q_waddr,
  output logic [bfq_pkg::ITEM_WIDTH-1:0] q_wdata,
  output logic [bfq_pkg::QADDR_W-1:0] q_raddr,
  output bfq_pkg::res_ctl_t       res_ctl
);
  import bfq_pkg::*;

  state_t              state, state_next;
  in_t                 cmd;
  logic [LCNT_W-1:0]   walk_cnt, walk_cnt_next;
  logic [LCNT_W-1:0]   log_count;
  logic [QADDR_W-1:0]  head, head_inc;
  logic [QCNT_W-1:0]   count;
  logic [QADDR_W:0]    tail_sum;
  logic                accept, is_direct, is_defer;
  logic                q_full, q_empty, log_full, walk_last;
  logic                apply_valid, apply_deq, q_pop;
  logic [ITEM_WIDTH-1:0] apply_item;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign is_direct = (op.opcode == OP_ENQ) || (op.opcode == OP_DEQ) ||
                     (op.opcode == OP_EXEC);
  assign is_defer  = (op.opcode == OP_DENQ) || (op.opcode == OP_DDEQ);
  assign q_full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty   = (count == '0);
  assign log_full  = (log_count == LCNT_W'(LOG_DEPTH));
  assign walk_last = ((walk_cnt + LCNT_W'(1)) == log_count);

  // Tail is head plus count, wrapped at the queue depth.
  always_comb begin
    tail_sum = (QADDR_W + 1)'(head) + (QADDR_W + 1)'(count);
    if (tail_sum >= (QADDR_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QADDR_W + 1)'(QUEUE_DEPTH);
    end
  end

  assign head_inc = (head == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head + QADDR_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_direct) begin
          if (log_count != '0) begin
            state_next = ST_WALK;
          end else if (op.opcode != OP_EXEC) begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
    endcase
  end

  // Outputs: which operation is applied this cycle and what it does.
  always_comb begin
    apply_valid   = 1'b0;
    apply_deq     = 1'b0;
    apply_item    = cmd.item;
    walk_cnt_next = walk_cnt;
    unique case (state)
      ST_IDLE: begin
        walk_cnt_next = '0;
      end
      ST_WALK: begin
        apply_valid   = 1'b1;
        apply_deq     = log_rdata.kind;
        apply_item    = log_rdata.item;
        walk_cnt_next = walk_cnt + LCNT_W'(1);
      end
      ST_FINAL: begin
        apply_valid = (cmd.opcode == OP_ENQ) || (cmd.opcode == OP_DEQ);
        apply_deq   = (cmd.opcode == OP_DEQ);
      end
      default: begin
      end
    endcase

    q_we    = apply_valid && !apply_deq && !q_full;
    q_pop   = apply_valid && apply_deq && !q_empty;
    q_waddr = tail_sum[QADDR_W-1:0];
    q_wdata = apply_item;
    q_raddr = head;

    res_ctl.push.valid   = apply_valid && (apply_deq || q_full);
    res_ctl.push.status  = apply_deq ? STAT_RESULT : STAT_QFULL;
    res_ctl.push.found   = q_pop;
    res_ctl.direct_lfull = accept && is_defer && log_full;
    res_ctl.flush        = (state == ST_DONE);

    log_we         = accept && is_defer && !log_full;
    log_waddr      = log_count[LADDR_W-1:0];
    log_wdata.kind = (op.opcode == OP_DDEQ);
    log_wdata.item = (op.opcode == OP_DDEQ) ? '0 : op.item;
    // The log is read one entry ahead so that its data is ready in the cycle
    // the entry is applied.
    log_raddr      = walk_cnt_next[LADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_cnt  <= '0;
      head      <= '0;
      count     <= '0;
      log_count <= '0;
    end else begin
      state    <= state_next;
      walk_cnt <= walk_cnt_next;
      if (q_pop) begin
        head <= head_inc;
      end
      if (q_we) begin
        count <= count + QCNT_W'(1);
      end else if (q_pop) begin
        count <= count - QCNT_W'(1);
      end
      if (log_we) begin
        log_count <= log_count + LCNT_W'(1);
      end else if ((state == ST_WALK) && walk_last) begin
        log_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= op;
    end
  end

endmodule
`default_nettype wire

// File: design/bfq_result.sv
// Result path: resolves dequeue data from the queue memory, holds one result
// back until it is known whether it is the last one, and drives the outputs.
// Depends on bfq_pkg.
`default_nettype none
module bfq_result (
  input  logic                          clk,
  input  logic                          rst,
  input  bfq_pkg::res_ctl_t             res_ctl,
  input  logic [bfq_pkg::ITEM_WIDTH-1:0] q_rdata,
  output bfq_pkg::out_t                 result,
  output logic                          result_valid
);
  import bfq_pkg::*;

  res_push_t stage;
  out_t      held, resolved;
  logic      held_valid;

  always_comb begin
    resolved.status   = stage.status;
    resolved.item_out = stage.found ? q_rdata : '0;
    resolved.found    = stage.found;
    resolved.last     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid  <= 1'b0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      stage        <= res_ctl.push;
      result_valid <= 1'b0;
      if (stage.valid) begin
        held_valid <= 1'b1;
        if (held_valid) begin
          result_valid <= 1'b1;
        end
      end else if (res_ctl.flush && held_valid) begin
        held_valid   <= 1'b0;
        result_valid <= 1'b1;
      end else if (res_ctl.direct_lfull) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      held <= resolved;
      result <= held;
    end else if (res_ctl.flush && held_valid) begin
      result <= '{status: held.status, item_out: held.item_out, found: held.found,
                  last: 1'b1};
    end else if (res_ctl.direct_lfull) begin
      result.status   <= STAT_LFULL;
      result.item_out <= '0;
      result.found    <= 1'b0;
      result.last     <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: design/batched_fifo_queue_top.sv
// Top level of the batched FIFO queue: queue and log memories, sequencer
// and result path. Depends on bfq_pkg, bfq_ram, bfq_ctrl and bfq_result.
//
//   Channel   Ports                    Handshake
//   command   start, busy, op          taken when start is high and busy low
//   result    result_valid, result     shown one cycle, cannot be stalled
//
// For a deferred enqueue or dequeue busy stays low, so a new item can follow
// at once; the same holds for an unused opcode and for an execute that finds
// the log empty, which cause no result. Enqueue, dequeue and an execute with
// a pending log walk the log one logged operation per cycle, then pass through
// ST_FINAL for the direct operation, ST_FLUSH for the read of the queue memory
// and ST_DONE for the release of the final result, with busy high throughout.
// The queue memory's registered read and the one-result holdback that marks
// the last result set that tail.
// Reset is synchronous and empties the queue and the log at once; the
// memories themselves are not cleared. Results cannot be held off, so each
// appears on result for exactly one cycle with result_valid high.
`default_nettype none
module batched_fifo_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bfq_pkg::in_t  op,
  output bfq_pkg::out_t result,
  output logic          result_valid
);
  import bfq_pkg::*;

  logic                  log_we;
  logic [LADDR_W-1:0]    log_waddr, log_raddr;
  log_entry_t            log_wdata, log_rdata;
  logic                  q_we;
  logic [QADDR_W-1:0]    q_waddr, q_raddr;
  logic [ITEM_WIDTH-1:0] q_wdata, q_rdata;
  res_ctl_t              res_ctl;

  // The log holds deferred operations in arrival order.
  bfq_ram #(
    .DEPTH (LOG_DEPTH),
    .WIDTH ($bits(log_entry_t)),
    .AW    (LADDR_W)
  ) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  // The queue is a circular buffer; the read port always follows the head,
  // so the data for a dequeue is ready in the cycle after it is applied.
  bfq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ITEM_WIDTH),
    .AW    (QADDR_W)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  bfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .busy      (busy),
    .log_we    (log_we),
    .log_waddr (log_waddr),
    .log_wdata (log_wdata),
    .log_raddr (log_raddr),
    .log_rdata (log_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_raddr   (q_raddr),
    .res_ctl   (res_ctl)
  );

  bfq_result u_result (
    .clk          (clk),
    .rst          (rst),
    .res_ctl      (res_ctl),
    .q_rdata      (q_rdata),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

// File: design/bfq_checker.sv
// Port-level checks for the batched FIFO queue, bound to the top level.
// Depends on bfq_pkg and batched_fifo_queue_top.
`default_nettype none
module bfq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input bfq_pkg::in_t  op,
  input bfq_pkg::out_t result,
  input logic          result_valid
);
  import bfq_pkg::*;

  // Nothing comes out in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result shown right after reset");

  // A deferred operation never makes the block busy.
  a_defer_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((op.opcode == OP_DENQ) || (op.opcode == OP_DDEQ)))
      |=> !busy)
    else $error("deferred operation held the command port");

  // Only a dequeue result can carry an item.
  a_found_is_dequeue: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.found) |-> (result.status == STAT_RESULT))
    else $error("found set on a refusal");

  // A null or refused result carries zero.
  a_null_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.item_out == '0))
    else $error("nonzero item on a null result");

  // A refused deferred operation is answered alone, in the next cycle, so its result is marked last.
  a_lfull_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STAT_LFULL)) |-> result.last)
    else $error("log full refusal not marked last");

endmodule

bind batched_fifo_queue_top bfq_checker u_bfq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .result       (result),
  .result_valid (result_valid)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for batched_fifo_queue_top: directed table, then random
// deferred-operation batches, a full-queue fill and drain, checked by a predictor.
// Depends on bfq_pkg and the batched_fifo_queue_top design files.
module tb_top;
  import bfq_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 6;
  localparam int RANDOM_ITEMS = 100;
  localparam int MAX_REPORTS  = 10;
  // The tail wait outlasts the worst item, which walks a full log of LOG_DEPTH entries.
  localparam int TAIL_CYCLES  = LOG_DEPTH + 12;
  // Roughly 800 items, each at the worst busy time and the longest gap, with a wide margin.
  localparam int CYCLE_LIMIT  = 400000;

  // Opcodes the block must ignore.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // One row of the directed table. A row may repeat; the item is XORed with the
  // repeat index so repeated rows still carry distinct values.
  typedef struct {
    logic [2:0]            opcode;
    logic [ITEM_WIDTH-1:0] item;
    int                    reps;
    bit                    typed;
    out_t                  typed_res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  op;
  out_t result;
  logic result_valid;

  batched_fifo_queue_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .result       (result),
    .result_valid (result_valid)
  );

  // Predictor state: the FIFO contents, its head and fill level, and the log of
  // deferred operations that have not been executed yet.
  logic [ITEM_WIDTH-1:0] fifo_mem [QUEUE_DEPTH];
  logic [QADDR_W-1:0]    fifo_head  = '0;
  logic [QCNT_W-1:0]     fifo_count = '0;
  logic                  log_is_deq [LOG_DEPTH];
  logic [ITEM_WIDTH-1:0] log_item   [LOG_DEPTH];
  logic [LCNT_W-1:0]     log_len    = '0;

  // Results of the item being predicted, and the results still owed by the block.
  out_t step_results[$];
  out_t pending_results[$];

  out_t      oldest_result;
  int        mismatch_count = 0;
  int        sent_count = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  stim_row_t directed_rows [12];

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs with busy high or owes results forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic out_t make_result(logic [1:0] st, logic [ITEM_WIDTH-1:0] v, logic f);
    out_t r;
    r.status   = st;
    r.item_out = v;
    r.found    = f;
    r.last     = 1'b0;
    return r;
  endfunction

  // Enqueue into the FIFO; a full FIFO drops the item and reports it.
  function automatic void fifo_push(logic [ITEM_WIDTH-1:0] v);
    if (fifo_count >= QUEUE_DEPTH) begin
      step_results.push_back(make_result(STAT_QFULL, '0, 1'b0));
    end else begin
      fifo_mem[QADDR_W'((int'(fifo_head) + int'(fifo_count)) % QUEUE_DEPTH)] = v;
      fifo_count++;
    end
  endfunction

  // Dequeue always yields a result; an empty FIFO gives the null result.
  function automatic void fifo_pop();
    logic [ITEM_WIDTH-1:0] v;
    if (fifo_count == 0) begin
      step_results.push_back(make_result(STAT_RESULT, '0, 1'b0));
    end else begin
      v = fifo_mem[fifo_head];
      fifo_head = QADDR_W'((int'(fifo_head) + 1) % QUEUE_DEPTH);
      fifo_count--;
      step_results.push_back(make_result(STAT_RESULT, v, 1'b1));
    end
  endfunction

  // Apply the deferred operations in the order they were logged, then clear the log.
  function automatic void replay_log();
    for (int i = 0; i < int'(log_len); i++) begin
      if (log_is_deq[LADDR_W'(i)]) fifo_pop();
      else fifo_push(log_item[LADDR_W'(i)]);
    end
    log_len = '0;
  endfunction

  function automatic void log_append(logic is_deq, logic [ITEM_WIDTH-1:0] v);
    if (log_len >= LOG_DEPTH) begin
      step_results.push_back(make_result(STAT_LFULL, '0, 1'b0));
    end else begin
      log_is_deq[log_len[LADDR_W-1:0]] = is_deq;
      log_item[log_len[LADDR_W-1:0]]   = v;
      log_len++;
    end
  endfunction

  // Works out every result one accepted item causes, in order, with the final
  // one marked as last.
  function automatic void predict_queue_op(in_t cmd);
    step_results.delete();
    case (cmd.opcode)
      OP_ENQ: begin
        replay_log();
        fifo_push(cmd.item);
      end
      OP_DEQ: begin
        replay_log();
        fifo_pop();
      end
      OP_DENQ: log_append(1'b0, cmd.item);
      OP_DDEQ: log_append(1'b1, '0);
      OP_EXEC: replay_log();
      default: ;
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string field, logic [ITEM_WIDTH-1:0] want,
                               logic [ITEM_WIDTH-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Results cannot be held off, so every cycle with result_valid is one result.
  // Outputs are read at the edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result (status)", '0, ITEM_WIDTH'(result.status));
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.status !== oldest_result.status)
          note_mismatch("status", ITEM_WIDTH'(oldest_result.status),
                        ITEM_WIDTH'(result.status));
        if (result.item_out !== oldest_result.item_out)
          note_mismatch("item_out", oldest_result.item_out, result.item_out);
        if (result.found !== oldest_result.found)
          note_mismatch("found", ITEM_WIDTH'(oldest_result.found),
                        ITEM_WIDTH'(result.found));
        if (result.last !== oldest_result.last)
          note_mismatch("last", ITEM_WIDTH'(oldest_result.last),
                        ITEM_WIDTH'(result.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ITEM_WIDTH-1:0] rand_item();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ITEM_WIDTH'($urandom);
    endcase
  endfunction

  // Presents one item, holds it until the block takes it, then records what the
  // block owes for it. A typed row replaces the prediction with its own value.
  task automatic issue(logic [2:0] opc, logic [ITEM_WIDTH-1:0] v, bit typed, out_t typed_res);
    in_t cmd;
    int  gap;
    cmd.opcode = opc;
    cmd.item   = v;
    start <= 1'b1;
    op    <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_op(cmd);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    if (opc <= OP_EXEC) sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [2:0] opc, logic [ITEM_WIDTH-1:0] v);
    issue(opc, v, 1'b0, '0);
  endtask

  // Sender holds off until the block has delivered everything it owes.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A run of deferred operations closed by execute or a direct operation.
  task automatic deferred_batch(int n_ops, int enq_pct, logic [2:0] closer);
    for (int i = 0; i < n_ops; i++) begin
      if ($urandom_range(0, 99) < enq_pct) send_op(OP_DENQ, rand_item());
      else send_op(OP_DDEQ, rand_item());
    end
    send_op(closer, rand_item());
  endtask

  // Random part: mostly batches with random content, some of them overflowing
  // the log, the rest single direct operations, bare executes and ignored opcodes.
  task automatic run_random(int target);
    int          base;
    int          r;
    int          n_ops;
    logic [2:0]  closer;
    base = sent_count;
    while (sent_count - base < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        n_ops = $urandom_range(1, LOG_DEPTH);
        if ($urandom_range(0, 9) == 0) n_ops = LOG_DEPTH + $urandom_range(1, 3);
        case ($urandom_range(0, 2))
          0:       closer = OP_EXEC;
          1:       closer = OP_ENQ;
          default: closer = OP_DEQ;
        endcase
        deferred_batch(n_ops, 55, closer);
      end else if (r < 82) begin
        send_op($urandom_range(0, 1) ? OP_ENQ : OP_DEQ, rand_item());
      end else if (r < 90) begin
        send_op(OP_EXEC, rand_item());
      end else begin
        send_op(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), rand_item());
      end
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    op    = '0;

    // Directed part. Rows with an obvious answer carry it; the rest go through
    // the predictor. The log is filled exactly to its depth, then one deferred
    // operation of each kind must be refused.
    directed_rows = '{
      '{OP_DEQ,       32'h0000_0000, 1,         1'b1, '{STAT_RESULT, 32'h0, 1'b0, 1'b1}},
      '{OP_EXEC,      32'h0000_0000, 1,         1'b0, '0},
      '{OP_UNUSED_LO, 32'hA5A5_5A5A, 1,         1'b0, '0},
      '{OP_UNUSED_HI, 32'hFFFF_FFFF, 1,         1'b0, '0},
      '{OP_ENQ,       32'hFFFF_FFFF, 1,         1'b0, '0},
      '{OP_ENQ,       32'h0000_0000, 1,         1'b0, '0},
      '{OP_DEQ,       32'h0000_0000, 1,         1'b1, '{STAT_RESULT, 32'hFFFF_FFFF, 1'b1, 1'b1}},
      '{OP_DENQ,      32'h8000_0001, LOG_DEPTH / 2, 1'b0, '0},
      '{OP_DDEQ,      32'h0000_0000, LOG_DEPTH / 2, 1'b0, '0},
      '{OP_DDEQ,      32'h0000_0000, 1,         1'b1, '{STAT_LFULL, 32'h0, 1'b0, 1'b1}},
      '{OP_DENQ,      32'h1234_5678, 1,         1'b1, '{STAT_LFULL, 32'h0, 1'b0, 1'b1}},
      '{OP_EXEC,      32'h0000_0000, 1,         1'b0, '0}
    };

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        issue(directed_rows[r].opcode, directed_rows[r].item ^ ITEM_WIDTH'(k),
              directed_rows[r].typed, directed_rows[r].typed_res);
      end
    end
    wait_drained();

    run_random(RANDOM_ITEMS / 2);
    wait_drained();

    // Fill the queue to the brim, mostly through executed batches so that a
    // logged enqueue hits the full queue, then refuse a direct enqueue, and let
    // a batch free one slot and overflow it again.
    no_idle = 1'b0;
    while (fifo_count < QUEUE_DEPTH) begin
      if ($urandom_range(0, 3) == 0) send_op(OP_ENQ, rand_item());
      else deferred_batch($urandom_range(4, LOG_DEPTH), 100, OP_EXEC);
    end
    send_op(OP_ENQ, rand_item());
    send_op(OP_DDEQ, rand_item());
    send_op(OP_DENQ, rand_item());
    send_op(OP_DENQ, rand_item());
    send_op(OP_DEQ, rand_item());

    // Drain it again; the head wraps on the way, and the last dequeue finds
    // the queue empty.
    while (fifo_count != 0) begin
      if ($urandom_range(0, 3) == 0) send_op(OP_DEQ, rand_item());
      else deferred_batch($urandom_range(4, LOG_DEPTH), 0, OP_EXEC);
    end
    send_op(OP_DEQ, rand_item());
    wait_drained();

    run_random(RANDOM_ITEMS / 2);
    send_op(OP_EXEC, '0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: batched_fifo_queue_top.f
design/bfq_pkg.sv
design/bfq_ram.sv
design/bfq_ctrl.sv
design/bfq_result.sv
design/batched_fifo_queue_top.sv
design/bfq_checker.sv
dv/tb_top.sv
